// ===== rtl/e2r_pkg.sv =====
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared types, constants and fixed-point helpers for the Euler-angle to
// rotation-matrix converter.
// ----------------------------------------------------------------------------
package e2r_pkg;

    localparam int WB    = 30;                     // fraction bits of Q2.30
    localparam int N_SIN = 5;
    localparam int N_COS = 6;
    localparam int NST_SC = 16;                    // stages in the sine/cosine unit
    localparam int NST_CB = 4;                     // stages in the matrix combiner

    localparam logic [30:0] ONE_Q = 31'h4000_0000;
    localparam logic [31:0] PI_Q  = 32'd3373259426;

    // Horner divisors, innermost term first
    localparam int SIN_K [N_SIN] = '{110, 72, 42, 20, 6};
    localparam int COS_K [N_COS] = '{132, 90, 56, 30, 12, 2};

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    typedef struct packed {
        logic [WB-1:0] x;      // octant angle in radians, Q0.30
        t_quad         q;
        logic          sw;     // angle folded back from the upper octant
    } t_side;

    // unsigned Q2.30 product, rounded half up
    function automatic logic [30:0] umulq(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + (62'd1 << (WB - 1));
        return p[WB +: 31];
    endfunction

    // signed Q2.30 product, magnitude rounded half up (half away from zero)
    function automatic logic signed [31:0] smulq(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic        neg;
        logic [30:0] ua;
        logic [30:0] ub;
        logic [30:0] ur;
        neg = a[31] ^ b[31];
        ua  = a[31] ? 31'(-a) : a[30:0];
        ub  = b[31] ? 31'(-b) : b[30:0];
        ur  = umulq(ua, ub);
        return neg ? -$signed({1'b0, ur}) : $signed({1'b0, ur});
    endfunction

endpackage

// ===== rtl/e2r_horner_cell.sv =====
// ----------------------------------------------------------------------------
// e2r_horner_cell
// One Horner step of the series: t' = 1 - rnd(x2 * t) / K, two stages.
// ----------------------------------------------------------------------------
module e2r_horner_cell #(
    parameter int K = 2
) (
    input  logic                  i_clk,
    input  logic [1:0]            i_en,
    input  logic [29:0]           i_x2,
    input  logic [30:0]           i_t,
    input  e2r_pkg::t_side        i_side,
    output logic [29:0]           o_x2,
    output logic [30:0]           o_t,
    output e2r_pkg::t_side        o_side
);

    // exact floor division by K for dividends below 2^30
    localparam int          SH    = e2r_pkg::WB + $clog2(K);
    localparam logic [31:0] RECIP = 32'(((64'd1 << SH) + 64'(K) - 64'd1) / 64'(K));

    logic [29:0]    r_p;
    logic [29:0]    r_x2a;
    e2r_pkg::t_side r_sidea;
    logic [30:0]    r_t;
    logic [29:0]    r_x2;
    e2r_pkg::t_side r_side;

    logic [30:0] w_p;
    logic [63:0] w_prod;
    logic [30:0] n_t;

    assign w_p    = e2r_pkg::umulq({1'b0, i_x2}, i_t);
    assign w_prod = (64'(r_p) * 64'(RECIP)) >> SH;
    assign n_t    = e2r_pkg::ONE_Q - w_prod[30:0];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p     <= w_p[29:0];
            r_x2a   <= i_x2;
            r_sidea <= i_side;
        end
        if (i_en[1]) begin
            r_t    <= n_t;
            r_x2   <= r_x2a;
            r_side <= r_sidea;
        end
    end

    assign o_x2   = r_x2;
    assign o_t    = r_t;
    assign o_side = r_side;

endmodule

// ===== rtl/e2r_sincos.sv =====
// ----------------------------------------------------------------------------
// e2r_sincos
// Sine and cosine of one binary angle in Q2.30: octant fold, radian scale,
// chains of Horner cells, and quadrant unfold.
// ----------------------------------------------------------------------------
module e2r_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic [e2r_pkg::NST_SC-1:0]          i_en,
    input  logic [15:0]                         i_angle,
    output logic signed [31:0]                  o_sin,
    output logic signed [31:0]                  o_cos
);

    localparam int QB = ANGLE_BITS - 2;
    localparam int PW = ANGLE_BITS + 31;
    localparam logic [QB-1:0] HALF = {1'b1, {(QB-1){1'b0}}};

    // fold
    logic [ANGLE_BITS-1:0] w_a;
    logic [QB-1:0]         w_f;
    logic                  w_sw;
    logic [QB-1:0]         r_r;
    e2r_pkg::t_quad        r_q1;
    logic                  r_sw1;

    assign w_a  = ANGLE_BITS'($signed(i_angle));
    assign w_f  = w_a[QB-1:0];
    assign w_sw = w_f > HALF;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_r   <= w_sw ? (~w_f) + QB'(1) : w_f;
            r_q1  <= e2r_pkg::t_quad'(w_a[ANGLE_BITS-1 -: 2]);
            r_sw1 <= w_sw;
        end
    end

    // radians: x = rnd(r * pi / 2^(ANGLE_BITS-1))
    logic [PW-1:0]  w_px;
    e2r_pkg::t_side r_side2;
    e2r_pkg::t_side r_side3;
    logic [29:0]    r_x2;
    logic [30:0]    w_x2;

    assign w_px = PW'(r_r) * PW'(e2r_pkg::PI_Q) + (PW'(1) << (ANGLE_BITS - 2));
    assign w_x2 = e2r_pkg::umulq({1'b0, r_side2.x}, {1'b0, r_side2.x});

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_side2.x  <= w_px[ANGLE_BITS-1 +: 30];
            r_side2.q  <= r_q1;
            r_side2.sw <= r_sw1;
        end
        if (i_en[2]) begin
            r_side3 <= r_side2;
            r_x2    <= w_x2[29:0];
        end
    end

    // Horner chains
    logic [29:0]    sin_x2   [e2r_pkg::N_SIN+1];
    logic [30:0]    sin_t    [e2r_pkg::N_SIN+1];
    e2r_pkg::t_side sin_side [e2r_pkg::N_SIN+1];
    logic [29:0]    cos_x2   [e2r_pkg::N_COS+1];
    logic [30:0]    cos_t    [e2r_pkg::N_COS+1];
    e2r_pkg::t_side cos_side [e2r_pkg::N_COS+1];

    assign sin_x2[0]   = r_x2;
    assign sin_t[0]    = e2r_pkg::ONE_Q;
    assign sin_side[0] = r_side3;
    assign cos_x2[0]   = r_x2;
    assign cos_t[0]    = e2r_pkg::ONE_Q;
    assign cos_side[0] = r_side3;

    for (genvar j = 0; j < e2r_pkg::N_SIN; j++) begin : g_sin
        e2r_horner_cell #(.K(e2r_pkg::SIN_K[j])) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en[3+2*j +: 2]),
            .i_x2   (sin_x2[j]),
            .i_t    (sin_t[j]),
            .i_side (sin_side[j]),
            .o_x2   (sin_x2[j+1]),
            .o_t    (sin_t[j+1]),
            .o_side (sin_side[j+1])
        );
    end

    for (genvar j = 0; j < e2r_pkg::N_COS; j++) begin : g_cos
        e2r_horner_cell #(.K(e2r_pkg::COS_K[j])) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en[3+2*j +: 2]),
            .i_x2   (cos_x2[j]),
            .i_t    (cos_t[j]),
            .i_side (cos_side[j]),
            .o_x2   (cos_x2[j+1]),
            .o_t    (cos_t[j+1]),
            .o_side (cos_side[j+1])
        );
    end

    // sine = x * t, then one stage to line up with the longer cosine chain
    logic [30:0] w_s;
    logic [30:0] r_s13;
    logic [30:0] r_s14;

    assign w_s = e2r_pkg::umulq({1'b0, sin_side[e2r_pkg::N_SIN].x}, sin_t[e2r_pkg::N_SIN]);

    always_ff @(posedge i_clk) begin
        if (i_en[13]) begin
            r_s13 <= w_s;
        end
        if (i_en[14]) begin
            r_s14 <= r_s13;
        end
    end

    // unfold octant and quadrant
    logic signed [31:0] w_s0;
    logic signed [31:0] w_c0;
    logic signed [31:0] n_sin;
    logic signed [31:0] n_cos;
    logic signed [31:0] r_sin;
    logic signed [31:0] r_cos;

    always_comb begin
        if (cos_side[e2r_pkg::N_COS].sw) begin
            w_s0 = $signed({1'b0, cos_t[e2r_pkg::N_COS]});
            w_c0 = $signed({1'b0, r_s14});
        end else begin
            w_s0 = $signed({1'b0, r_s14});
            w_c0 = $signed({1'b0, cos_t[e2r_pkg::N_COS]});
        end
        case (cos_side[e2r_pkg::N_COS].q)
            e2r_pkg::QUAD_0: begin
                n_sin = w_s0;
                n_cos = w_c0;
            end
            e2r_pkg::QUAD_1: begin
                n_sin = w_c0;
                n_cos = -w_s0;
            end
            e2r_pkg::QUAD_2: begin
                n_sin = -w_s0;
                n_cos = -w_c0;
            end
            default: begin
                n_sin = -w_c0;
                n_cos = w_s0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[15]) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== rtl/e2r_combine.sv =====
// ----------------------------------------------------------------------------
// e2r_combine
// Forms the nine matrix elements from the sines and cosines: two product
// levels, the sums, then rounding to Q1.FRAC_BITS with saturation.
// ----------------------------------------------------------------------------
module e2r_combine #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic [e2r_pkg::NST_CB-1:0]    i_en,
    input  logic signed [31:0]            i_sh,
    input  logic signed [31:0]            i_ch,
    input  logic signed [31:0]            i_sp,
    input  logic signed [31:0]            i_cp,
    input  logic signed [31:0]            i_sb,
    input  logic signed [31:0]            i_cb,
    output logic [8:0][15:0]              o_m
);

    localparam int          SHF = e2r_pkg::WB - FRAC_BITS;
    localparam logic [33:0] RND = 34'd1 << (SHF - 1);
    localparam logic [33:0] LIM = 34'd1 << FRAC_BITS;

    // first product level
    logic signed [31:0] r_cbch, r_spsh, r_sbcp, r_cbsh, r_sbsp;
    logic signed [31:0] r_sbch, r_cbcp, r_sbsh, r_cpsh, r_cpch;
    logic signed [31:0] r_sb1, r_ch1, r_cb1, r_sp1;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_cbch <= e2r_pkg::smulq(i_cb, i_ch);
            r_spsh <= e2r_pkg::smulq(i_sp, i_sh);
            r_sbcp <= e2r_pkg::smulq(i_sb, i_cp);
            r_cbsh <= e2r_pkg::smulq(i_cb, i_sh);
            r_sbsp <= e2r_pkg::smulq(i_sb, i_sp);
            r_sbch <= e2r_pkg::smulq(i_sb, i_ch);
            r_cbcp <= e2r_pkg::smulq(i_cb, i_cp);
            r_sbsh <= e2r_pkg::smulq(i_sb, i_sh);
            r_cpsh <= e2r_pkg::smulq(i_cp, i_sh);
            r_cpch <= e2r_pkg::smulq(i_cp, i_ch);
            r_sb1  <= i_sb;
            r_ch1  <= i_ch;
            r_cb1  <= i_cb;
            r_sp1  <= i_sp;
        end
    end

    // second product level
    logic signed [31:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [31:0] r_cbch2, r_sbcp2, r_cbsh2, r_sbch2, r_cbcp2;
    logic signed [31:0] r_sbsh2, r_cpsh2, r_cpch2, r_sp2;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_pa    <= e2r_pkg::smulq(r_sb1, r_spsh);
            r_pb    <= e2r_pkg::smulq(r_sbsp, r_ch1);
            r_pc    <= e2r_pkg::smulq(r_cb1, r_spsh);
            r_pd    <= e2r_pkg::smulq(r_sp1, r_cbch);
            r_cbch2 <= r_cbch;
            r_sbcp2 <= r_sbcp;
            r_cbsh2 <= r_cbsh;
            r_sbch2 <= r_sbch;
            r_cbcp2 <= r_cbcp;
            r_sbsh2 <= r_sbsh;
            r_cpsh2 <= r_cpsh;
            r_cpch2 <= r_cpch;
            r_sp2   <= r_sp1;
        end
    end

    // sums in Q3.30
    logic signed [32:0] r_sum [9];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_sum[0] <= 33'(r_cbch2) + 33'(r_pa);
            r_sum[1] <= 33'(r_sbcp2);
            r_sum[2] <= 33'(r_pb) - 33'(r_cbsh2);
            r_sum[3] <= 33'(r_pc) - 33'(r_sbch2);
            r_sum[4] <= 33'(r_cbcp2);
            r_sum[5] <= 33'(r_sbsh2) + 33'(r_pd);
            r_sum[6] <= 33'(r_cpsh2);
            r_sum[7] <= -33'(r_sp2);
            r_sum[8] <= 33'(r_cpch2);
        end
    end

    // round half away from zero, clamp to +-1
    logic [33:0]      w_mag [9];
    logic [33:0]      w_rnd [9];
    logic [33:0]      w_res [9];
    logic [8:0][15:0] n_m;
    logic [8:0][15:0] r_m;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_mag[i] = r_sum[i][32] ? 34'(-r_sum[i]) : 34'(r_sum[i]);
            w_rnd[i] = (w_mag[i] + RND) >> SHF;
            if (w_rnd[i] > LIM) begin
                w_rnd[i] = LIM;
            end
            w_res[i] = r_sum[i][32] ? -w_rnd[i] : w_rnd[i];
            n_m[i]   = w_res[i][15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_m <= n_m;
        end
    end

    assign o_m = r_m;

endmodule

// ===== rtl/euler_to_rotation_matrix_top.sv =====
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top
// Heading/pitch/bank binary angles to the 3x3 rotation matrix in Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per cycle unless a full pipeline is stalled.
// Each angle runs through its own sine/cosine unit (fold, radian scale,
// chains of Horner cells of two stages each, the six-cell cosine chain sets
// the length), then two product levels, the sums and the rounding stage,
// which is the output register. Every stage has its own valid bit and loads
// whenever it is empty or the stage after it loads, so bubbles close up and
// input keeps flowing while a finished request waits at the output, until
// all 20 stages hold requests.
module euler_to_rotation_matrix_top #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [47:0]   i_s_tdata,   // heading[15:0], pitch[31:16], bank[47:32]
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [143:0]  o_m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

    localparam int NST = e2r_pkg::NST_SC + e2r_pkg::NST_CB;

    logic [NST:1] r_v;
    logic [NST:1] w_en;

    assign w_en[NST] = !r_v[NST] || i_m_tready;
    for (genvar k = 1; k < NST; k++) begin : g_ready
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    logic signed [31:0] w_s [3];
    logic signed [31:0] w_c [3];

    for (genvar a = 0; a < 3; a++) begin : g_angle
        e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos (
            .i_clk   (i_clk),
            .i_en    (w_en[e2r_pkg::NST_SC:1]),
            .i_angle (i_s_tdata[16*a +: 16]),
            .o_sin   (w_s[a]),
            .o_cos   (w_c[a])
        );
    end

    logic [8:0][15:0] w_m;

    e2r_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
        .i_clk (i_clk),
        .i_en  (w_en[NST:e2r_pkg::NST_SC+1]),
        .i_sh  (w_s[0]),
        .i_ch  (w_c[0]),
        .i_sp  (w_s[1]),
        .i_cp  (w_c[1]),
        .i_sb  (w_s[2]),
        .i_cb  (w_c[2]),
        .o_m   (w_m)
    );

    assign o_s_tready = w_en[1];
    assign o_m_tvalid = r_v[NST];
    assign o_m_tdata  = w_m;

    a_accept_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v[1])
        else $error("accepted request did not enter the pipeline");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-1] && !w_en[NST]) |=> r_v[NST-1])
        else $error("stalled request dropped ahead of the output stage");

    a_stall_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without a blocked output");

endmodule
